FILE: design/id3p_pkg.sv
// shared types, codes and helper functions of the id3v2 tag and frame parser
package id3p_pkg;

  typedef enum logic [1:0] {
    PH_HEADER   = 2'd0,
    PH_FRAMEHDR = 2'd1,
    PH_CONTENT  = 2'd2,
    PH_SKIP     = 2'd3
  } phase_t;

  localparam logic [2:0] EV_TAG_OK      = 3'd0;
  localparam logic [2:0] EV_NOT_ID3     = 3'd1;
  localparam logic [2:0] EV_BAD_VERSION = 3'd2;
  localparam logic [2:0] EV_FRAME_START = 3'd3;
  localparam logic [2:0] EV_CONTENT     = 3'd4;
  localparam logic [2:0] EV_PADDING     = 3'd5;
  localparam logic [2:0] EV_TAG_END     = 3'd6;

  localparam logic [3:0] KIND_APIC    = 4'd11;
  localparam logic [3:0] KIND_UNKNOWN = 4'd12;
  localparam int unsigned NumKnown    = 12;

  localparam logic [23:0] SIG_ID3      = 24'h494433;
  localparam logic [7:0]  VER_3        = 8'h03;
  localparam logic [7:0]  VER_4        = 8'h04;
  localparam logic [7:0]  ENC_UTF16    = 8'h01;
  localparam logic [7:0]  ID_TEXT_HEAD = 8'h54;
  localparam logic [31:0] ID_COMM      = 32'h434F4D4D;

  localparam logic [3:0] POS_VERSION   = 4'd3;
  localparam logic [3:0] POS_ID_DONE   = 4'd3;
  localparam logic [3:0] POS_SIZE_DONE = 4'd7;
  localparam logic [3:0] POS_ADD_CALC  = 4'd8;
  localparam logic [3:0] POS_LAST_HDR  = 4'd9;

  // frame ids in kind order
  localparam logic [31:0] KNOWN_IDS [NumKnown] = '{
    32'h54495432, // TIT2
    32'h54504531, // TPE1
    32'h54414C42, // TALB
    32'h54594552, // TYER
    32'h5452434B, // TRCK
    32'h54434F4E, // TCON
    32'h434F4D4D, // COMM
    32'h54504532, // TPE2
    32'h54434F4D, // TCOM
    32'h54434F50, // TCOP
    32'h54505542, // TPUB
    32'h41504943  // APIC
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic        valid;
    logic [2:0]  event_kind;
    logic [3:0]  frame_kind;
    logic [31:0] value;
    logic        frame_last;
  } result_t;

  // 7 low bits of each byte, msb first
  function automatic logic [27:0] synchsafe(input logic [31:0] w);
    synchsafe = {w[30:24], w[22:16], w[14:8], w[6:0]};
  endfunction

  function automatic logic [3:0] classify(input logic [31:0] id);
    logic [3:0] k;
    k = KIND_UNKNOWN;
    for (int i = NumKnown - 1; i >= 0; i--) begin
      if (KNOWN_IDS[i] == id) begin
        k = 4'(i);
      end
    end
    classify = k;
  endfunction

endpackage

FILE: design/id3p_in_stage.sv
// input register stage of the id3v2 parser
module id3p_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  id3p_pkg::in_item_t in_item,
  input  logic              room,
  output logic              advance,
  output id3p_pkg::in_item_t item
);

  logic held;

  assign advance  = held && room;
  assign in_ready = !held || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

FILE: design/id3p_engine.sv
// parse state and per-byte result logic of the id3v2 parser
module id3p_engine (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  id3p_pkg::in_item_t item,
  output id3p_pkg::result_t  res
);

  id3p_pkg::phase_t phase, phase_next;
  logic [3:0]  byte_position, byte_position_next;
  logic [31:0] header_shift, header_shift_next;
  logic        is_version_four, is_version_four_next;
  logic [27:0] total_tag_size, total_tag_size_next;
  logic [31:0] consumed_count, consumed_count_next;
  logic [31:0] current_frame_size, current_frame_size_next;
  logic [31:0] frame_add, frame_add_next;
  logic [31:0] content_index, content_index_next;
  logic [3:0]  current_kind, current_kind_next;
  logic        strip_utf16, strip_utf16_next;
  logic        text_like_frame, text_like_frame_next;

  logic [7:0]  b;
  logic [31:0] hs_new;
  logic        sig_ok, ver_ok, tag_done, content_last, strip_eff;
  logic [31:0] index_inc;
  logic [32:0] add_wide, sum_wide;

  assign b         = item.data_byte;
  assign hs_new    = {header_shift[23:0], b};
  assign sig_ok    = (hs_new[31:8] == id3p_pkg::SIG_ID3);
  assign ver_ok    = (b == id3p_pkg::VER_3) || (b == id3p_pkg::VER_4);
  assign tag_done  = (consumed_count >= {4'd0, total_tag_size});
  assign index_inc = content_index + 32'd1;
  assign content_last = (index_inc == current_frame_size);
  assign strip_eff = (content_index == 32'd0) ? (text_like_frame && (b == id3p_pkg::ENC_UTF16))
                                              : strip_utf16;
  assign add_wide  = {1'b0, current_frame_size} + 33'd10;
  assign sum_wide  = {1'b0, consumed_count} + {1'b0, frame_add};

  always_comb begin
    phase_next = phase;
    unique case (phase)
      id3p_pkg::PH_HEADER: begin
        if (byte_position == id3p_pkg::POS_VERSION && (!sig_ok || !ver_ok)) begin
          phase_next = id3p_pkg::PH_SKIP;
        end else if (byte_position >= id3p_pkg::POS_LAST_HDR) begin
          phase_next = id3p_pkg::PH_FRAMEHDR;
        end
      end
      id3p_pkg::PH_FRAMEHDR: begin
        if (byte_position == 4'd0 && (tag_done || b == 8'd0)) begin
          phase_next = id3p_pkg::PH_SKIP;
        end else if (byte_position >= id3p_pkg::POS_LAST_HDR) begin
          phase_next = (current_frame_size == 32'd0) ? id3p_pkg::PH_FRAMEHDR
                                                     : id3p_pkg::PH_CONTENT;
        end
      end
      id3p_pkg::PH_CONTENT: begin
        if (content_last) begin
          phase_next = id3p_pkg::PH_FRAMEHDR;
        end
      end
      id3p_pkg::PH_SKIP: begin
        phase_next = id3p_pkg::PH_SKIP;
      end
      default: begin
        phase_next = id3p_pkg::PH_HEADER;
      end
    endcase
    if (item.end_of_file) begin
      phase_next = id3p_pkg::PH_HEADER;
    end
  end

  always_comb begin
    byte_position_next      = byte_position;
    header_shift_next       = header_shift;
    is_version_four_next    = is_version_four;
    total_tag_size_next     = total_tag_size;
    consumed_count_next     = consumed_count;
    current_frame_size_next = current_frame_size;
    frame_add_next          = frame_add;
    content_index_next      = content_index;
    current_kind_next       = current_kind;
    strip_utf16_next        = strip_utf16;
    text_like_frame_next    = text_like_frame;
    res                     = '0;

    unique case (phase)
      id3p_pkg::PH_HEADER: begin
        header_shift_next = hs_new;
        if (byte_position == id3p_pkg::POS_VERSION && !sig_ok) begin
          res.valid      = 1'b1;
          res.event_kind = id3p_pkg::EV_NOT_ID3;
        end else if (byte_position == id3p_pkg::POS_VERSION && !ver_ok) begin
          res.valid      = 1'b1;
          res.event_kind = id3p_pkg::EV_BAD_VERSION;
          res.value      = {24'd0, b};
        end else begin
          if (byte_position == id3p_pkg::POS_VERSION) begin
            is_version_four_next = (b == id3p_pkg::VER_4);
          end
          if (byte_position >= id3p_pkg::POS_LAST_HDR) begin
            total_tag_size_next = id3p_pkg::synchsafe(hs_new);
            consumed_count_next = 32'd0;
            byte_position_next  = 4'd0;
            res.valid           = 1'b1;
            res.event_kind      = id3p_pkg::EV_TAG_OK;
            res.value           = is_version_four ? {24'd0, id3p_pkg::VER_4}
                                                  : {24'd0, id3p_pkg::VER_3};
          end else begin
            byte_position_next = byte_position + 4'd1;
          end
        end
      end
      id3p_pkg::PH_FRAMEHDR: begin
        if (byte_position == 4'd0 && tag_done) begin
          res.valid      = 1'b1;
          res.event_kind = id3p_pkg::EV_TAG_END;
        end else if (byte_position == 4'd0 && b == 8'd0) begin
          res.valid      = 1'b1;
          res.event_kind = id3p_pkg::EV_PADDING;
          res.value      = {4'd0, total_tag_size} - consumed_count;
        end else begin
          header_shift_next = hs_new;
          if (byte_position == id3p_pkg::POS_ID_DONE) begin
            current_kind_next    = id3p_pkg::classify(hs_new);
            text_like_frame_next = (hs_new[31:24] == id3p_pkg::ID_TEXT_HEAD) ||
                                   (hs_new == id3p_pkg::ID_COMM);
          end else if (byte_position == id3p_pkg::POS_SIZE_DONE) begin
            current_frame_size_next = is_version_four ? {4'd0, id3p_pkg::synchsafe(hs_new)}
                                                      : hs_new;
          end else if (byte_position == id3p_pkg::POS_ADD_CALC) begin
            // frame header plus body, saturated
            frame_add_next = add_wide[32] ? 32'hFFFF_FFFF : add_wide[31:0];
          end
          if (byte_position >= id3p_pkg::POS_LAST_HDR) begin
            consumed_count_next = sum_wide[32] ? 32'hFFFF_FFFF : sum_wide[31:0];
            byte_position_next  = 4'd0;
            content_index_next  = 32'd0;
            strip_utf16_next    = 1'b0;
            res.valid           = 1'b1;
            res.event_kind      = id3p_pkg::EV_FRAME_START;
            res.frame_kind      = current_kind;
            res.value           = current_frame_size;
          end else begin
            byte_position_next = byte_position + 4'd1;
          end
        end
      end
      id3p_pkg::PH_CONTENT: begin
        strip_utf16_next = strip_eff;
        if (current_kind != id3p_pkg::KIND_UNKNOWN) begin
          res.event_kind = id3p_pkg::EV_CONTENT;
          res.frame_kind = current_kind;
          res.frame_last = content_last;
          if (!strip_eff) begin
            res.valid = 1'b1;
            res.value = {24'd0, b};
          end else if (content_index == 32'd0) begin
            res.valid = 1'b1;
            res.value = 32'd0;
          end else if (content_index >= 32'd3 && content_index[0] && b != 8'd0) begin
            res.valid = 1'b1;
            res.value = {24'd0, b};
          end
          if (!res.valid) begin
            res.event_kind = id3p_pkg::EV_TAG_OK;
            res.frame_kind = 4'd0;
            res.frame_last = 1'b0;
          end
        end
        if (content_last) begin
          byte_position_next = 4'd0;
        end else begin
          content_index_next = index_inc;
        end
      end
      id3p_pkg::PH_SKIP: begin
        res = '0;
      end
      default: begin
        res = '0;
      end
    endcase

    if (item.end_of_file) begin
      byte_position_next      = 4'd0;
      header_shift_next       = 32'd0;
      is_version_four_next    = 1'b0;
      total_tag_size_next     = 28'd0;
      consumed_count_next     = 32'd0;
      current_frame_size_next = 32'd0;
      frame_add_next          = 32'd0;
      content_index_next      = 32'd0;
      current_kind_next       = id3p_pkg::KIND_UNKNOWN;
      strip_utf16_next        = 1'b0;
      text_like_frame_next    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= id3p_pkg::PH_HEADER;
      byte_position      <= 4'd0;
      header_shift       <= 32'd0;
      is_version_four    <= 1'b0;
      total_tag_size     <= 28'd0;
      consumed_count     <= 32'd0;
      current_frame_size <= 32'd0;
      frame_add          <= 32'd0;
      content_index      <= 32'd0;
      current_kind       <= id3p_pkg::KIND_UNKNOWN;
      strip_utf16        <= 1'b0;
      text_like_frame    <= 1'b0;
    end else if (advance) begin
      phase              <= phase_next;
      byte_position      <= byte_position_next;
      header_shift       <= header_shift_next;
      is_version_four    <= is_version_four_next;
      total_tag_size     <= total_tag_size_next;
      consumed_count     <= consumed_count_next;
      current_frame_size <= current_frame_size_next;
      frame_add          <= frame_add_next;
      content_index      <= content_index_next;
      current_kind       <= current_kind_next;
      strip_utf16        <= strip_utf16_next;
      text_like_frame    <= text_like_frame_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_eof_restarts: assert property (@(posedge clk) disable iff (rst)
    advance && item.end_of_file |=> phase == id3p_pkg::PH_HEADER && byte_position == 4'd0)
    else $error("end of file did not return the parser to header search");

  a_last_is_content: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.frame_last |-> res.event_kind == id3p_pkg::EV_CONTENT)
    else $error("frame_last on a non-content word");

  a_kind_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.event_kind != id3p_pkg::EV_CONTENT &&
    res.event_kind != id3p_pkg::EV_FRAME_START |-> res.frame_kind == 4'd0)
    else $error("frame kind set on a tag-level word");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    byte_position <= id3p_pkg::POS_LAST_HDR)
    else $error("header byte position out of range");
`endif

endmodule

FILE: design/id3p_out_stage.sv
// result register of the id3v2 parser
module id3p_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  id3p_pkg::result_t res,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        event_kind,
  output logic [3:0]        frame_kind,
  output logic [31:0]       value,
  output logic              frame_last
);

  assign room = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (room) begin
      out_valid <= advance && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (room && advance && res.valid) begin
      event_kind <= res.event_kind;
      frame_kind <= res.frame_kind;
      value      <= res.value;
      frame_last <= res.frame_last;
    end
  end

endmodule

FILE: design/id3v2_tag_frame_parser_core.sv
// top level of the id3v2 tag and frame parser
// Takes a file one byte per word on the slave stream (tlast marks the last byte of the file)
// and reports tag and frame events on the master stream. The 10-byte header is checked for
// the ID3 signature and major version 3 or 4, then frame headers are walked and content
// bytes of known frames are passed on, with a simple utf-16 strip for text and comment
// frames whose encoding byte is 1. A byte enters an input register, is decoded in one
// pass against the parse state, and its result (zero or one word) lands in an output
// register. One byte is taken per clock cycle while the master side is not stalled; a byte
// passes the input register and then the output register (two register stages) before its
// result is valid on the master side, and a stalled master side holds the input side after
// at most one more byte has been buffered. Bytes that cause no result are simply absorbed.
module id3v2_tag_frame_parser_core (
  input  logic        clk,
  input  logic        rst,
  // byte stream in
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // end_of_file
  // event stream out
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] value
  output logic [6:0]  m_tuser,   // [2:0] event_kind, [6:3] frame_kind
  output logic        m_tlast    // frame_last
);

  id3p_pkg::in_item_t in_item;
  id3p_pkg::in_item_t item;
  id3p_pkg::result_t  res;
  logic               room;
  logic               advance;
  logic [2:0]         event_kind;
  logic [3:0]         frame_kind;

  assign in_item.data_byte   = s_tdata;
  assign in_item.end_of_file = s_tlast;

  // input register, loads whenever it is empty or the decode stage moves on
  id3p_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_item  (in_item),
    .room     (room),
    .advance  (advance),
    .item     (item)
  );

  // parse state and per-byte decode
  id3p_engine u_engine (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (item),
    .res     (res)
  );

  // result register toward the master side
  id3p_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .res        (res),
    .room       (room),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .event_kind (event_kind),
    .frame_kind (frame_kind),
    .value      (m_tdata),
    .frame_last (m_tlast)
  );

  assign m_tuser = {frame_kind, event_kind};

endmodule

FILE: test/testbench.sv
// testbench of the id3v2 tag and frame parser: random and directed files in, predicted events checked
`timescale 1ns / 100ps

module testbench;

  localparam int ByteTarget = 1300;

  typedef struct {
    logic [2:0]  ev;
    logic [3:0]  fk;
    logic [31:0] val;
    logic        last;
  } tag_event_t;

  // predicts the event stream of the parser and checks words against it
  class tag_event_scoreboard;
    id3p_pkg::phase_t ph;
    logic [3:0]  pos;
    logic [31:0] shreg;
    bit          v4;
    logic [27:0] tag_len;
    logic [31:0] used;
    logic [31:0] fsize;
    logic [31:0] cidx;
    logic [3:0]  kind;
    bit          utf16;
    bit          textish;
    tag_event_t  pending_events[$];
    int          bad_count;
    int          bytes_parsed;
    int          words_checked;
    int          ev_seen[8];

    function new();
      clear_state();
      bad_count = 0;
      bytes_parsed = 0;
      words_checked = 0;
      foreach (ev_seen[i]) ev_seen[i] = 0;
    endfunction

    function void clear_state();
      ph = id3p_pkg::PH_HEADER;
      pos = '0;
      shreg = '0;
      v4 = 1'b0;
      tag_len = '0;
      used = '0;
      fsize = '0;
      cidx = '0;
      kind = id3p_pkg::KIND_UNKNOWN;
      utf16 = 1'b0;
      textish = 1'b0;
    endfunction

    function void expect_event(logic [2:0] ev, logic [3:0] fk, logic [31:0] val, logic last);
      tag_event_t e;
      e.ev = ev;
      e.fk = fk;
      e.val = val;
      e.last = last;
      pending_events.push_back(e);
    endfunction

    function int pending();
      return pending_events.size();
    endfunction

    // one accepted byte of the file
    function void parse_byte(logic [7:0] b, logic eof);
      logic        lastb;
      logic [32:0] step_sum;
      logic [32:0] new_used;
      if (ph != id3p_pkg::PH_SKIP) bytes_parsed++;
      case (ph)
        id3p_pkg::PH_HEADER: begin
          shreg = {shreg[23:0], b};
          if (pos == id3p_pkg::POS_VERSION && shreg[31:8] != id3p_pkg::SIG_ID3) begin
            ph = id3p_pkg::PH_SKIP;
            expect_event(id3p_pkg::EV_NOT_ID3, 4'd0, 32'd0, 1'b0);
          end else if (pos == id3p_pkg::POS_VERSION && b != id3p_pkg::VER_3 &&
                       b != id3p_pkg::VER_4) begin
            ph = id3p_pkg::PH_SKIP;
            expect_event(id3p_pkg::EV_BAD_VERSION, 4'd0, {24'd0, b}, 1'b0);
          end else begin
            if (pos == id3p_pkg::POS_VERSION) v4 = (b == id3p_pkg::VER_4);
            if (pos >= id3p_pkg::POS_LAST_HDR) begin
              tag_len = {shreg[30:24], shreg[22:16], shreg[14:8], shreg[6:0]};
              used = '0;
              ph = id3p_pkg::PH_FRAMEHDR;
              pos = '0;
              expect_event(id3p_pkg::EV_TAG_OK, 4'd0,
                           {24'd0, v4 ? id3p_pkg::VER_4 : id3p_pkg::VER_3}, 1'b0);
            end else begin
              pos++;
            end
          end
        end
        id3p_pkg::PH_FRAMEHDR: begin
          if (pos == 4'd0 && used >= {4'd0, tag_len}) begin
            ph = id3p_pkg::PH_SKIP;
            expect_event(id3p_pkg::EV_TAG_END, 4'd0, 32'd0, 1'b0);
          end else if (pos == 4'd0 && b == 8'h00) begin
            ph = id3p_pkg::PH_SKIP;
            expect_event(id3p_pkg::EV_PADDING, 4'd0, {4'd0, tag_len} - used, 1'b0);
          end else begin
            shreg = {shreg[23:0], b};
            if (pos == id3p_pkg::POS_ID_DONE) begin
              kind = id3p_pkg::KIND_UNKNOWN;
              for (int k = id3p_pkg::NumKnown - 1; k >= 0; k--) begin
                if (id3p_pkg::KNOWN_IDS[k] == shreg) kind = 4'(k);
              end
              textish = (shreg[31:24] == id3p_pkg::ID_TEXT_HEAD) || (shreg == id3p_pkg::ID_COMM);
            end else if (pos == id3p_pkg::POS_SIZE_DONE) begin
              fsize = v4 ? {4'd0, shreg[30:24], shreg[22:16], shreg[14:8], shreg[6:0]} : shreg;
            end
            if (pos >= id3p_pkg::POS_LAST_HDR) begin
              // header plus size, both steps saturating
              step_sum = {1'b0, fsize} + 33'd10;
              if (step_sum[32]) step_sum = {1'b0, 32'hFFFF_FFFF};
              new_used = {1'b0, used} + step_sum;
              used = new_used[32] ? 32'hFFFF_FFFF : new_used[31:0];
              pos = '0;
              cidx = '0;
              utf16 = 1'b0;
              ph = (fsize == 32'd0) ? id3p_pkg::PH_FRAMEHDR : id3p_pkg::PH_CONTENT;
              expect_event(id3p_pkg::EV_FRAME_START, kind, fsize, 1'b0);
            end else begin
              pos++;
            end
          end
        end
        id3p_pkg::PH_CONTENT: begin
          lastb = (cidx == fsize - 32'd1);
          if (cidx == 32'd0) utf16 = textish && (b == id3p_pkg::ENC_UTF16);
          if (kind != id3p_pkg::KIND_UNKNOWN) begin
            if (!utf16) begin
              expect_event(id3p_pkg::EV_CONTENT, kind, {24'd0, b}, lastb);
            end else if (cidx == 32'd0) begin
              expect_event(id3p_pkg::EV_CONTENT, kind, 32'd0, lastb);
            end else if (cidx >= 32'd3 && cidx[0] && b != 8'h00) begin
              expect_event(id3p_pkg::EV_CONTENT, kind, {24'd0, b}, lastb);
            end
          end
          if (lastb) begin
            ph = id3p_pkg::PH_FRAMEHDR;
            pos = '0;
          end else begin
            cidx++;
          end
        end
        default: ;
      endcase
      if (eof) clear_state();
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      bad_count++;
      $display("%0t mismatch: %s, got %0h, expected %0h", $time, what, got, want);
    endtask

    task check_word(logic [31:0] data, logic [6:0] user, logic last);
      tag_event_t e;
      if (pending_events.size() == 0) begin
        report_mismatch("word with no event pending", data, 32'd0);
      end else begin
        e = pending_events.pop_front();
        words_checked++;
        ev_seen[e.ev]++;
        if (user[2:0] != e.ev) report_mismatch("event kind", {29'd0, user[2:0]}, {29'd0, e.ev});
        if (user[6:3] != e.fk) report_mismatch("frame kind", {28'd0, user[6:3]}, {28'd0, e.fk});
        if (data != e.val) report_mismatch("value", data, e.val);
        if (last != e.last) report_mismatch("frame last", {31'd0, last}, {31'd0, e.last});
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [6:0]  m_tuser;
  logic        m_tlast;

  bit          steady = 1'b0;
  logic [7:0]  file_bytes[$];
  int          files_sent = 0;
  int          bytes_sent = 0;

  tag_event_scoreboard sb = new();

  id3v2_tag_frame_parser_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #1 clk = ~clk;

  function automatic bit idle_roll();
    return !steady && ($urandom_range(0, 99) < 38);
  endfunction

  always @(negedge clk) begin
    m_tready <= !idle_roll();
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.parse_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) sb.check_word(m_tdata, m_tuser, m_tlast);
    end
  end

  // called at a falling edge, returns at the falling edge after the accept
  task automatic push_byte(input logic [7:0] b, input logic last);
    while (idle_roll()) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_file();
    for (int i = 0; i < file_bytes.size(); i++) begin
      push_byte(file_bytes[i], i == file_bytes.size() - 1);
    end
    files_sent++;
  endtask

  // a mostly well formed tag: frames, sometimes padding, then trailing audio, sometimes cut short
  task automatic build_tag();
    int          nframes;
    int          fsz;
    int          choice;
    int          total;
    int          extra;
    int          cut;
    logic [31:0] fid;
    logic [31:0] szf;
    logic [27:0] tsz;
    logic [7:0]  ver;
    bit          v4;
    bit          utf;
    bit          overrun;
    file_bytes.delete();
    v4 = 1'($urandom_range(0, 1));
    nframes = $urandom_range(0, 4);
    total = 0;
    overrun = 1'b0;
    for (int f = 0; f < nframes && !overrun; f++) begin
      choice = $urandom_range(0, 9);
      if (choice < 6) fid = id3p_pkg::KNOWN_IDS[$urandom_range(0, id3p_pkg::NumKnown - 1)];
      else if (choice < 8) fid = {id3p_pkg::ID_TEXT_HEAD, 24'($urandom)};
      else fid = $urandom;
      if (fid[31:24] == 8'h00) fid[31:24] = 8'h41;
      fsz = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) : $urandom_range(0, 14);
      // a size far beyond the content, so the frame runs into the end of file
      overrun = ($urandom_range(0, 29) == 0);
      if (overrun) szf = {$urandom_range(0, 1) ? 8'hFF : 8'h7F, 24'($urandom)};
      else if (v4) szf = {1'($urandom), 7'(fsz >> 21), 1'($urandom), 7'(fsz >> 14),
                          1'($urandom), 7'(fsz >> 7), 1'($urandom), 7'(fsz)};
      else szf = 32'(fsz);
      for (int k = 3; k >= 0; k--) file_bytes.push_back(fid[8*k +: 8]);
      for (int k = 3; k >= 0; k--) file_bytes.push_back(szf[8*k +: 8]);
      file_bytes.push_back(8'($urandom));
      file_bytes.push_back(8'($urandom));
      utf = (fid[31:24] == id3p_pkg::ID_TEXT_HEAD || fid == id3p_pkg::ID_COMM) && fsz > 0 &&
            $urandom_range(0, 1);
      for (int i = 0; i < fsz; i++) begin
        if (utf && i == 0) file_bytes.push_back(id3p_pkg::ENC_UTF16);
        else if (utf && i == 1) file_bytes.push_back(8'hFF);
        else if (utf && i == 2) file_bytes.push_back(8'hFE);
        else if ($urandom_range(0, 3) == 0) file_bytes.push_back(8'h00);
        else file_bytes.push_back(8'($urandom));
      end
      total += 10 + fsz;
    end
    choice = $urandom_range(0, 3);
    case (choice)
      0: begin
        extra = $urandom_range(1, 6);
        repeat (extra) file_bytes.push_back(8'h00);
        tsz = 28'(total + extra);
      end
      1: tsz = 28'(total);
      2: begin
        extra = $urandom_range(1, 20);
        tsz = (total > extra) ? 28'(total - extra) : 28'd0;
      end
      default: tsz = 28'(total + $urandom_range(1, 30));
    endcase
    repeat ($urandom_range(1, 4)) file_bytes.push_back(8'($urandom));
    ver = v4 ? id3p_pkg::VER_4 : id3p_pkg::VER_3;
    if ($urandom_range(0, 19) == 0) ver = 8'($urandom);
    file_bytes.push_front({1'($urandom), tsz[6:0]});
    file_bytes.push_front({1'($urandom), tsz[13:7]});
    file_bytes.push_front({1'($urandom), tsz[20:14]});
    file_bytes.push_front({1'($urandom), tsz[27:21]});
    file_bytes.push_front(8'($urandom));
    file_bytes.push_front(8'($urandom));
    file_bytes.push_front(ver);
    file_bytes.push_front(id3p_pkg::SIG_ID3[7:0]);
    file_bytes.push_front(id3p_pkg::SIG_ID3[15:8]);
    file_bytes.push_front(id3p_pkg::SIG_ID3[23:16]);
    if ($urandom_range(0, 19) == 0) file_bytes[$urandom_range(0, 2)] = 8'($urandom);
    if ($urandom_range(0, 6) == 0) begin
      cut = $urandom_range(1, file_bytes.size());
      while (file_bytes.size() > cut) void'(file_bytes.pop_back());
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // wrong signature
    file_bytes = {8'h49, 8'h44, 8'h58, 8'h03};
    send_file();
    // unsupported major version
    file_bytes = {8'h49, 8'h44, 8'h33, 8'hFF};
    send_file();
    // zero tag size, tag ends on the byte after the header
    file_bytes = {8'h49, 8'h44, 8'h33, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h7F};
    send_file();
    // end of file inside the header
    file_bytes = {8'h49, 8'h44};
    send_file();

    while (bytes_sent < ByteTarget) begin
      steady = (bytes_sent >= 500 && bytes_sent < 800);
      if ($urandom_range(0, 9) == 0) begin
        file_bytes.delete();
        repeat ($urandom_range(1, 12)) file_bytes.push_back(8'($urandom));
      end else begin
        build_tag();
      end
      send_file();
    end
    s_tvalid <= 1'b0;
    steady = 1'b0;

    for (int w = 0; w < 5000 && sb.pending() > 0; w++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.pending() > 0) begin
      sb.report_mismatch("events never produced", 32'(sb.pending()), 32'd0);
    end

    $display("sent %0d files, %0d bytes, %0d of them parsed; checked %0d words",
             files_sent, bytes_sent, sb.bytes_parsed, sb.words_checked);
    $display("frame starts %0d, content %0d, padding %0d, tag ends %0d, header rejects %0d",
             sb.ev_seen[id3p_pkg::EV_FRAME_START], sb.ev_seen[id3p_pkg::EV_CONTENT],
             sb.ev_seen[id3p_pkg::EV_PADDING], sb.ev_seen[id3p_pkg::EV_TAG_END],
             sb.ev_seen[id3p_pkg::EV_NOT_ID3] + sb.ev_seen[id3p_pkg::EV_BAD_VERSION]);
    if (sb.bad_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("testbench failed");
    $finish;
  end

endmodule
